@@ rtl/core/pfrl_pkg.sv @@
package pfrl_pkg;

  // fixed arithmetic constants
  localparam int GRADE_DEG_MUL = 57;
  localparam int SLOW_SPEED    = 4096;
  localparam int STALL_DELTA   = 3;
  localparam int UNIT_ONE      = 65536;

  // x/100 is done as (x>>2)*RECIP_25 >> RECIP_SHIFT, exact for x below 2^22
  localparam int RECIP_25    = 671089;
  localparam int RECIP_SHIFT = 24;

  // configuration register indexes
  localparam logic [2:0] REG_MAX_MAG_RULE = 3'd0;
  localparam logic [2:0] REG_FOLLOW_PCT   = 3'd1;
  localparam logic [2:0] REG_BLEND_ALPHA  = 3'd2;
  localparam logic [2:0] REG_BOOM_PCT     = 3'd3;
  localparam logic [2:0] REG_DEADZONE     = 3'd4;
  localparam logic [2:0] REG_MAX_PITCH    = 3'd5;
  localparam logic [2:0] REG_STEP_IN      = 3'd6;
  localparam logic [2:0] REG_STEP_OUT     = 3'd7;

  // step limits handed to the rate limiter
  typedef struct packed {
    logic [6:0] max_pitch;
    logic [3:0] max_in;
    logic [3:0] max_out;
  } pfrl_limits_t;

endpackage

@@ rtl/core/pfrl_step_unit.sv @@
module pfrl_step_unit import pfrl_pkg::*; (
  input  logic signed [7:0] cur,
  input  logic signed [7:0] tgt,
  input  logic signed [9:0] delta,
  input  logic signed [9:0] step_raw,
  input  pfrl_limits_t      lims,
  output logic signed [7:0] nxt
);

  localparam logic signed [10:0] STALL = 11'(STALL_DELTA);

  logic signed [10:0] mi, mo, lm, d, ad, c, tg, st, sum;

  assign mi = $signed({7'b0, lims.max_in});
  assign mo = $signed({7'b0, lims.max_out});
  assign lm = $signed({4'b0, lims.max_pitch});
  assign d  = {delta[9], delta};
  assign ad = d[10] ? -d : d;
  assign c  = {{3{cur[7]}}, cur};
  assign tg = {{3{tgt[7]}}, tgt};

  // asymmetric step limit, stall nudge and output clamp
  always_comb begin
    st = {step_raw[9], step_raw};
    if (d > 11'sd0) begin
      if (st > mi) st = mi;
      if (st < -mo) st = -mo;
    end else begin
      if (st > mo) st = mo;
      if (st < -mi) st = -mi;
      // leaving nose-down with a step that rounded to nothing
      if (c > 11'sd0 && tg < c && st > -mo && st > -11'sd1 && d <= -STALL) st = -11'sd1;
    end
    if (st == 11'sd0 && ad >= STALL) begin
      if (d > 11'sd0) st = 11'sd1;
      else if (mo > 11'sd1) st = -11'sd2;
      else st = -11'sd1;
    end
    sum = c + st;
    if (sum > lm) sum = lm;
    if (sum < -lm) sum = -lm;
    nxt = sum[7:0];
  end

endmodule

@@ rtl/core/pitch_follow_rate_limiter_top.sv @@
// pitch follow rate limiter
// s_* carries one attitude sample per request; s_tuser set clears both
// channels and the started flag before that sample is processed.
// m_* returns the camera and boom pitch for every sample, one for one.
// cfg_we/cfg_addr/cfg_data write one register per cycle; the user must write only while
// idle, the block itself does not enforce it. one shared 21x21 signed multiplier is reused
// for eight operations per sample (grade scale, three divides by 100, two percent scales,
// two smoothing gains), each passing through a multiply step and a post step. a result is
// registered at the end of the last post step; the next sample is only taken once the
// sequencer has run all eight passes and returned to idle.
// s_tready is high only while the sequencer is idle. a finished result sits
// in the output register, so the next sample is taken while it waits; if it
// is still not taken when the next result is ready, the sequencer holds in
// its last step until m_tready frees the register.
// reset (rst, synchronous) restores register defaults, clears both channels
// and the started flag, and drops m_tvalid. the first sample after reset or
// restart returns zero for both channels.
module pitch_follow_rate_limiter_top import pfrl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // grade_tan_x100[15:0], body_pitch_deg[24:16], speed_norm[41:25]
  input  logic        s_tuser,   // restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // cam_pitch_deg[7:0], boom_pitch_deg[15:8]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  localparam logic [2:0] OP_GRADE     = 3'd0;
  localparam logic [2:0] OP_GP_DIV    = 3'd1;
  localparam logic [2:0] OP_BOOM_MUL  = 3'd2;
  localparam logic [2:0] OP_BOOM_DIV  = 3'd3;
  localparam logic [2:0] OP_CAM_MUL   = 3'd4;
  localparam logic [2:0] OP_CAM_DIV   = 3'd5;
  localparam logic [2:0] OP_BOOM_STEP = 3'd6;
  localparam logic [2:0] OP_CAM_STEP  = 3'd7;

  // configuration
  logic        max_mag_rule;
  logic [6:0]  follow_pct;
  logic [16:0] blend_alpha;
  logic [6:0]  boom_pct;
  logic [4:0]  deadzone;
  logic [6:0]  max_pitch;
  logic [3:0]  step_in;
  logic [3:0]  step_out;

  // control and channel state
  logic [1:0]        state;
  logic [2:0]        op;
  logic              started;
  logic signed [7:0] cam, boom;

  // datapath
  logic signed [20:0] opa, opb;
  logic signed [41:0] prod;
  logic               neg;
  logic [8:0]         body;
  logic [16:0]        speed;
  logic signed [16:0] target;
  logic signed [7:0]  boom_t, cam_t;

  logic [41:0]        prod_mag;
  logic signed [20:0] div_opa;
  logic [15:0]        quo;
  logic signed [16:0] div_q, target_val;
  logic signed [7:0]  chan_val, step_cur, step_tgt, step_nxt, ch_final;
  logic signed [9:0]  delta_boom, delta_cam;
  logic [16:0]        alpha_sat;
  logic               go_out, last_post;
  pfrl_limits_t       lims;

  // merge grade and body into one target, low speed deadzone
  function automatic logic signed [16:0] calc_target(
    input logic signed [16:0] gp,
    input logic signed [8:0]  bp,
    input logic               rule,
    input logic [16:0]        spd,
    input logic [4:0]         dz
  );
    logic signed [17:0] g, b, ag, ab, s, avg, mild, s2, t, at;
    g  = {gp[16], gp};
    b  = {{9{bp[8]}}, bp};
    ag = g[17] ? -g : g;
    ab = b[17] ? -b : b;
    s  = g + b;
    avg = (s + $signed({17'b0, s[17]})) >>> 1;
    mild = (ag < ab) ? g : b;
    s2 = avg + mild;
    if (rule) t = (ab > ag) ? b : g;
    else t = (s2 + $signed({17'b0, s2[17]})) >>> 1;
    at = t[17] ? -t : t;
    if (spd < 17'(SLOW_SPEED) && at < $signed({13'b0, dz}) + 18'sd2) t = 18'sd0;
    return t[16:0];
  endfunction

  // channel deadzone and clamp
  function automatic logic signed [7:0] chan_target(
    input logic signed [16:0] tq,
    input logic [4:0]         dz,
    input logic [6:0]         lim
  );
    logic signed [17:0] tt, at, lm;
    tt = {tq[16], tq};
    at = tt[17] ? -tt : tt;
    lm = $signed({11'b0, lim});
    if (at < $signed({13'b0, dz})) tt = 18'sd0;
    if (tt > lm) tt = lm;
    if (tt < -lm) tt = -lm;
    return tt[7:0];
  endfunction

  // divide-by-100 prep and finish around the shared multiplier
  assign prod_mag = prod[41] ? 42'(-prod) : 42'(prod);
  assign div_opa  = $signed({1'b0, prod_mag[21:2]});
  assign quo      = prod[RECIP_SHIFT+15:RECIP_SHIFT];
  assign div_q    = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  assign target_val = calc_target(div_q, $signed(body), max_mag_rule, speed, deadzone);
  assign chan_val   = chan_target(div_q, deadzone, max_pitch);

  assign delta_boom = {{2{boom_t[7]}}, boom_t} - {{2{boom[7]}}, boom};
  assign delta_cam  = {{2{cam_t[7]}}, cam_t} - {{2{cam[7]}}, cam};
  assign alpha_sat  = (blend_alpha > 17'(UNIT_ONE)) ? 17'(UNIT_ONE) : blend_alpha;

  assign lims.max_pitch = max_pitch;
  assign lims.max_in    = step_in;
  assign lims.max_out   = step_out;

  assign step_cur = (op == OP_CAM_STEP) ? cam : boom;
  assign step_tgt = (op == OP_CAM_STEP) ? cam_t : boom_t;

  pfrl_step_unit u_step (
    .cur      (step_cur),
    .tgt      (step_tgt),
    .delta    (opa[9:0]),
    .step_raw (prod[25:16]),
    .lims     (lims),
    .nxt      (step_nxt)
  );

  assign ch_final  = started ? step_nxt : 8'sd0;
  assign go_out    = !m_tvalid || m_tready;
  assign last_post = (state == ST_POST) && (op == OP_CAM_STEP);
  assign s_tready  = (state == ST_IDLE);

  // sequencer, configuration and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op           <= OP_GRADE;
      started      <= 1'b0;
      cam          <= 8'sd0;
      boom         <= 8'sd0;
      m_tvalid     <= 1'b0;
      max_mag_rule <= 1'b0;
      follow_pct   <= 7'd40;
      blend_alpha  <= 17'd16384;
      boom_pct     <= 7'd50;
      deadzone     <= 5'd2;
      max_pitch    <= 7'd12;
      step_in      <= 4'd1;
      step_out     <= 4'd2;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MAX_MAG_RULE: max_mag_rule <= cfg_data[0];
          REG_FOLLOW_PCT:   follow_pct   <= cfg_data[6:0];
          REG_BLEND_ALPHA:  blend_alpha  <= cfg_data;
          REG_BOOM_PCT:     boom_pct     <= cfg_data[6:0];
          REG_DEADZONE:     deadzone     <= cfg_data[4:0];
          REG_MAX_PITCH:    max_pitch    <= cfg_data[6:0];
          REG_STEP_IN:      step_in      <= cfg_data[3:0];
          REG_STEP_OUT:     step_out     <= cfg_data[3:0];
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              cam     <= 8'sd0;
              boom    <= 8'sd0;
              started <= 1'b0;
            end
            op    <= OP_GRADE;
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_POST;
        ST_POST: begin
          if (op == OP_CAM_STEP) begin
            if (go_out) begin
              cam     <= ch_final;
              started <= 1'b1;
              state   <= ST_IDLE;
            end
          end else begin
            if (op == OP_BOOM_STEP) boom <= ch_final;
            op    <= op + 3'd1;
            state <= ST_MUL;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // output register
      if (last_post && go_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // operand, product and result registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      opa   <= {{5{s_tdata[15]}}, s_tdata[15:0]};
      opb   <= 21'(GRADE_DEG_MUL);
      body  <= s_tdata[24:16];
      speed <= s_tdata[41:25];
    end
    if (state == ST_MUL) prod <= opa * opb;
    if (state == ST_POST) begin
      unique case (op)
        OP_GRADE, OP_BOOM_MUL, OP_CAM_MUL: begin
          opa <= div_opa;
          opb <= 21'(RECIP_25);
          neg <= prod[41];
        end
        OP_GP_DIV: begin
          target <= target_val;
          opa    <= {{4{target_val[16]}}, target_val};
          opb    <= $signed({14'b0, boom_pct});
        end
        OP_BOOM_DIV: begin
          boom_t <= chan_val;
          opa    <= {{4{target[16]}}, target};
          opb    <= $signed({14'b0, follow_pct});
        end
        OP_CAM_DIV: begin
          cam_t <= chan_val;
          opa   <= {{11{delta_boom[9]}}, delta_boom};
          opb   <= $signed({4'b0, alpha_sat});
        end
        OP_BOOM_STEP: begin
          opa <= {{11{delta_cam[9]}}, delta_cam};
        end
        OP_CAM_STEP: begin
          if (go_out) m_tdata <= {boom, ch_final};
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // a result only appears from the last step of the sequence
  a_rise_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(last_post))
    else $error("result raised outside the final step");

  // a stalled output register holds the sequencer in its last step
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (last_post && m_tvalid && !m_tready) |=> last_post)
    else $error("sequencer left final step while output was blocked");

  // every delivered result comes after started is set
  a_started: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> started)
    else $error("result without started flag");

  // no result right after a sample is taken
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result too soon after request");
`endif

endmodule
